@@ rtl/gnts_pkg.sv @@
`default_nettype none

package gnts_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 8;

  localparam int unsigned UID_W     = 8;
  localparam int unsigned POWER_W   = 16;
  localparam int unsigned ENERGY_W  = 32;
  localparam int unsigned ACT_W     = 16;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned EIDX_W    = 3;
  localparam int unsigned OCNT_W    = 4;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 16;

  localparam logic [UID_W-1:0]   LOCAL_UID_RST   = '0;
  localparam logic [POWER_W-1:0] CONSUME_THR_RST = 16'd1;
  localparam logic [ACT_W-1:0]   ACT_CEIL_RST    = 16'd150;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD    = 2'd0,
    KIND_REPORT = 2'd1,
    KIND_SWITCH = 2'd2,
    KIND_REMOVE = 2'd3
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_FULL      = 2'd2,
    STATUS_BAD_INDEX = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOCAL_UID   = 2'd0,
    CFG_CONSUME_THR = 2'd1,
    CFG_ACT_CEIL    = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_APPLY,
    S_SHIFT,
    S_SUMMARY,
    S_RESULT
  } ctrl_state_e;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [UID_W-1:0]   uid;
    logic [POWER_W-1:0] power;
    logic               switch_on;
    logic [EIDX_W-1:0]  entry_index;
  } gnts_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [OCNT_W-1:0]   node_count;
    logic [OCNT_W-1:0]   consuming_count;
    logic [OCNT_W-1:0]   shed_count;
    logic [UID_W-1:0]    busiest_uid;
    logic                busiest_valid;
    logic [UID_W-1:0]    quietest_shed_uid;
    logic                quietest_valid;
  } gnts_result_t;

  // One table row.
  typedef struct packed {
    logic [UID_W-1:0]    id;
    logic [POWER_W-1:0]  power;
    logic [ENERGY_W-1:0] energy;
    logic [ACT_W-1:0]    act;
    logic                shed;
  } gnts_entry_t;

  typedef struct packed {
    logic item_load;
    logic scan_init;
    logic shift_init;
    logic scan_step;
    logic lookup_en;
    logic shift_en;
    logic sum_en;
    logic apply;
    logic count_dec;
    logic result_load;
  } gnts_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              scan_done;
    logic              remove_bad;
    logic              out_busy;
  } gnts_sts_t;

endpackage

`default_nettype wire

@@ rtl/gnts_in_if.sv @@
`default_nettype none

interface gnts_in_if import gnts_pkg::*; ();
  logic       valid;
  logic       ready;
  gnts_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/gnts_out_if.sv @@
`default_nettype none

interface gnts_out_if import gnts_pkg::*; ();
  logic         valid;
  logic         ready;
  gnts_result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/gnts_ctrl.sv @@
`default_nettype none

module gnts_ctrl import gnts_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic [KIND_W-1:0] in_kind_i,
  input  wire gnts_sts_t         sts_i,
  output logic                   in_ready_o,
  output gnts_cmd_t              cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.item_load = 1'b1;
          cmd_o.scan_init = 1'b1;
          if (in_kind_i == KIND_REPORT || in_kind_i == KIND_SWITCH) begin
            state_d = S_LOOKUP;
          end else begin
            state_d = S_APPLY;
          end
        end
      end
      S_LOOKUP: begin
        cmd_o.scan_step = 1'b1;
        cmd_o.lookup_en = 1'b1;
        if (sts_i.scan_done) begin
          state_d = S_APPLY;
        end
      end
      S_APPLY: begin
        cmd_o.apply = 1'b1;
        if (sts_i.kind == KIND_REMOVE && !sts_i.remove_bad) begin
          cmd_o.shift_init = 1'b1;
          state_d          = S_SHIFT;
        end else begin
          cmd_o.scan_init = 1'b1;
          state_d         = S_SUMMARY;
        end
      end
      S_SHIFT: begin
        cmd_o.scan_step = 1'b1;
        cmd_o.shift_en  = 1'b1;
        if (sts_i.scan_done) begin
          cmd_o.count_dec = 1'b1;
          cmd_o.scan_init = 1'b1;
          state_d         = S_SUMMARY;
        end
      end
      S_SUMMARY: begin
        cmd_o.scan_step = 1'b1;
        cmd_o.sum_en    = 1'b1;
        if (sts_i.scan_done) begin
          state_d = S_RESULT;
        end
      end
      S_RESULT: begin
        if (!sts_i.out_busy) begin
          cmd_o.result_load = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/gnts_dp.sv @@
`default_nettype none

module gnts_dp import gnts_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_wdata_i,
  input  wire gnts_item_t           item_i,
  input  wire gnts_cmd_t            cmd_i,
  input  wire logic                 out_ready_i,
  output gnts_sts_t                 sts_o,
  output logic                      out_valid_o,
  output gnts_result_t              out_data_o
);

  localparam int unsigned AW   = $clog2(TABLE_DEPTH);
  localparam int unsigned CW   = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CMPW = (CW > EIDX_W) ? CW : EIDX_W;

  // Configuration registers.
  logic [UID_W-1:0]   local_uid_q;
  logic [POWER_W-1:0] thr_q;
  logic [ACT_W-1:0]   ceil_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_uid_q <= LOCAL_UID_RST;
      thr_q       <= CONSUME_THR_RST;
      ceil_q      <= ACT_CEIL_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LOCAL_UID:   local_uid_q <= cfg_wdata_i[UID_W-1:0];
        CFG_CONSUME_THR: thr_q       <= cfg_wdata_i[POWER_W-1:0];
        CFG_ACT_CEIL:    ceil_q      <= cfg_wdata_i[ACT_W-1:0];
        default: ;
      endcase
    end
  end

  gnts_item_t item_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.item_load) begin
      item_q <= item_i;
    end
  end

  // Table memory and its control.
  gnts_entry_t mem [TABLE_DEPTH];
  gnts_entry_t rd_q;
  logic        rd_zero_q;

  logic [CW-1:0] count_q;
  logic [CW-1:0] ptr_q;
  logic          proc_q;
  logic [AW-1:0] proc_idx_q;
  logic          e0_valid_q;

  logic          rd_en;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  gnts_entry_t   wr_data;
  gnts_entry_t   entry_c;
  gnts_entry_t   upd_c;
  gnts_entry_t   new_c;

  logic          found_q;
  logic [AW-1:0] hit_q;
  gnts_entry_t   hit_entry_q;

  logic full_c;
  logic bad_c;
  logic lk_hit;
  logic [STATUS_W-1:0] status_c;
  logic [STATUS_W-1:0] status_q;
  logic [ENERGY_W:0]   e_sum;

  assign rd_en  = cmd_i.scan_step && (ptr_q < count_q);
  assign full_c = (count_q == CW'(TABLE_DEPTH));
  assign bad_c  = (item_q.entry_index == '0) ||
                  (CMPW'(item_q.entry_index) >= CMPW'(count_q));

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q      <= mem[ptr_q[AW-1:0]];
      rd_zero_q <= (ptr_q == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Entry zero always carries the local UID, and reads as cleared until first written.
  always_comb begin
    entry_c = rd_q;
    if (rd_zero_q) begin
      entry_c.id = local_uid_q;
      if (!e0_valid_q) begin
        entry_c.power  = '0;
        entry_c.energy = '0;
        entry_c.act    = '0;
        entry_c.shed   = 1'b0;
      end
    end
  end

  // Updated copy of the matched entry for a power report or a switch.
  always_comb begin
    e_sum = {1'b0, hit_entry_q.energy} + (ENERGY_W + 1)'(item_q.power);
    upd_c = hit_entry_q;
    if (item_q.kind == KIND_REPORT) begin
      upd_c.energy = e_sum[ENERGY_W] ? '1 : e_sum[ENERGY_W-1:0];
      if (item_q.power > hit_entry_q.power && hit_entry_q.act != '1) begin
        upd_c.act = hit_entry_q.act + ACT_W'(1);
      end
      upd_c.power = item_q.power;
    end else begin
      upd_c.shed = !item_q.switch_on;
    end
    new_c    = '0;
    new_c.id = item_q.uid;
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = upd_c;
    if (cmd_i.apply) begin
      if (item_q.kind == KIND_ADD && !full_c) begin
        wr_en   = 1'b1;
        wr_addr = count_q[AW-1:0];
        wr_data = new_c;
      end else if ((item_q.kind == KIND_REPORT || item_q.kind == KIND_SWITCH) &&
                   found_q) begin
        wr_en   = 1'b1;
        wr_addr = hit_q;
      end
    end else if (cmd_i.shift_en && proc_q) begin
      // Move the entry just read one place down.
      wr_en   = 1'b1;
      wr_addr = proc_idx_q - AW'(1);
      wr_data = rd_q;
    end
  end

  always_comb begin
    case (item_q.kind)
      KIND_ADD:    status_c = full_c ? STATUS_FULL : STATUS_OK;
      KIND_REPORT,
      KIND_SWITCH: status_c = found_q ? STATUS_OK : STATUS_NOT_FOUND;
      KIND_REMOVE: status_c = bad_c ? STATUS_BAD_INDEX : STATUS_OK;
      default:     status_c = STATUS_OK;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.apply) begin
      status_q <= status_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= CW'(1);
      e0_valid_q <= 1'b0;
      ptr_q      <= '0;
      proc_q     <= 1'b0;
    end else begin
      proc_q <= rd_en;
      if (wr_en && wr_addr == '0) begin
        e0_valid_q <= 1'b1;
      end
      if (cmd_i.apply && item_q.kind == KIND_ADD && !full_c) begin
        count_q <= count_q + CW'(1);
      end else if (cmd_i.count_dec) begin
        count_q <= count_q - CW'(1);
      end
      if (cmd_i.scan_init) begin
        ptr_q <= '0;
      end else if (cmd_i.shift_init) begin
        ptr_q <= CW'(CMPW'(item_q.entry_index) + CMPW'(1));
      end else if (rd_en) begin
        ptr_q <= ptr_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    proc_idx_q <= ptr_q[AW-1:0];
  end

  // Lookup: a power report keeps the last match, a switch the first.
  assign lk_hit = cmd_i.lookup_en && proc_q && (entry_c.id == item_q.uid) &&
                  (item_q.kind == KIND_REPORT || !found_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_init) begin
      found_q <= 1'b0;
    end else if (lk_hit) begin
      found_q     <= 1'b1;
      hit_q       <= proc_idx_q;
      hit_entry_q <= entry_c;
    end
  end

  // Summary accumulators.
  logic [CW-1:0]    cons_cnt_q;
  logic [CW-1:0]    shed_cnt_q;
  logic [ACT_W-1:0] best_act_q;
  logic [UID_W-1:0] best_uid_q;
  logic             best_ok_q;
  logic [ACT_W-1:0] quiet_min_q;
  logic [UID_W-1:0] quiet_uid_q;
  logic             quiet_ok_q;
  logic             sum_c;

  assign sum_c = cmd_i.sum_en && proc_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_init) begin
      cons_cnt_q  <= '0;
      shed_cnt_q  <= '0;
      best_act_q  <= '0;
      best_uid_q  <= '0;
      best_ok_q   <= 1'b0;
      quiet_min_q <= ceil_q;
      quiet_uid_q <= '0;
      quiet_ok_q  <= 1'b0;
    end else if (sum_c) begin
      if (entry_c.power > thr_q) begin
        cons_cnt_q <= cons_cnt_q + CW'(1);
        if (entry_c.act > best_act_q) begin
          best_act_q <= entry_c.act;
          best_uid_q <= entry_c.id;
          best_ok_q  <= 1'b1;
        end
      end
      if (entry_c.shed) begin
        shed_cnt_q <= shed_cnt_q + CW'(1);
        if (entry_c.act < quiet_min_q) begin
          quiet_min_q <= entry_c.act;
          quiet_uid_q <= entry_c.id;
          quiet_ok_q  <= 1'b1;
        end
      end
    end
  end

  // Output register.
  logic         out_valid_q;
  gnts_result_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.result_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.result_load) begin
      out_q.status            <= status_q;
      out_q.node_count        <= OCNT_W'(count_q);
      out_q.consuming_count   <= OCNT_W'(cons_cnt_q);
      out_q.shed_count        <= OCNT_W'(shed_cnt_q);
      out_q.busiest_uid       <= best_uid_q;
      out_q.busiest_valid     <= best_ok_q;
      out_q.quietest_shed_uid <= quiet_uid_q;
      out_q.quietest_valid    <= quiet_ok_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign sts_o.kind       = item_q.kind;
  assign sts_o.scan_done  = !(ptr_q < count_q) && !proc_q;
  assign sts_o.remove_bad = bad_c;
  assign sts_o.out_busy   = out_valid_q && !out_ready_i;

endmodule

`default_nettype wire

@@ rtl/grid_node_table_shed_select_unit.sv @@
// An add applies and then walks the table for the summary; a power report or switch first walks
// it for the lookup, and a valid remove also walks it to shift entries down. Each table walk reads
// one entry per cycle through the single read port of the table memory.
// A new word is accepted in the cycle after the previous result is loaded into the output.
// Reset: configuration registers take their defaults and the table holds only the local
// node; there is no clearing pass, so the block accepts words right after reset.
`default_nettype none

module grid_node_table_shed_select_unit import gnts_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_wdata_i,
  gnts_in_if.sink                   item_i,
  gnts_out_if.source                result_o
);

  gnts_cmd_t cmd;
  gnts_sts_t sts;
  logic      in_ready;

  gnts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_kind_i  (item_i.data.kind),
    .sts_i      (sts),
    .in_ready_o (in_ready),
    .cmd_o      (cmd)
  );

  gnts_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (item_i.data),
    .cmd_i       (cmd),
    .out_ready_i (result_o.ready),
    .sts_o       (sts),
    .out_valid_o (result_o.valid),
    .out_data_o  (result_o.data)
  );

  assign item_i.ready = in_ready;

endmodule

`default_nettype wire

@@ dv/grid_node_table_shed_select_unit_tb.sv @@
`default_nettype none

module grid_node_table_shed_select_unit_tb import gnts_pkg::*; ();

  localparam int unsigned DEPTH            = TABLE_DEPTH_DEF;
  localparam int unsigned CYCLE_LIMIT      = 400000;
  localparam int unsigned RANDOM_PER_PHASE = 150;
  localparam int unsigned NUM_PHASES       = 5;
  localparam int unsigned DRAIN_CYCLES     = 40;
  localparam int unsigned STEADY_WORDS     = 60;

  typedef struct packed {
    gnts_item_t   w;
    logic         typed;
    gnts_result_t r;
  } dir_row_t;

  localparam gnts_result_t UNTYPED = '0;
  localparam gnts_result_t LONE_BAD_INDEX =
      '{STATUS_BAD_INDEX, 4'd1, 4'd0, 4'd0, 8'h00, 1'b0, 8'h00, 1'b0};
  localparam gnts_result_t LONE_NOT_FOUND =
      '{STATUS_NOT_FOUND, 4'd1, 4'd0, 4'd0, 8'h00, 1'b0, 8'h00, 1'b0};
  localparam gnts_result_t LONE_BUSY =
      '{STATUS_OK, 4'd1, 4'd1, 4'd0, 8'h00, 1'b1, 8'h00, 1'b0};

  // Directed words; rows with typed set carry their result, the rest use the predictor.
  localparam dir_row_t DIR_ROWS [25] = '{
    '{'{KIND_REMOVE, 8'h00, 16'h0000, 1'b0, 3'd0}, 1'b1, LONE_BAD_INDEX},
    '{'{KIND_REPORT, 8'h55, 16'h0000, 1'b0, 3'd0}, 1'b1, LONE_NOT_FOUND},
    '{'{KIND_SWITCH, 8'hAA, 16'h0000, 1'b1, 3'd0}, 1'b1, LONE_NOT_FOUND},
    '{'{KIND_REMOVE, 8'h00, 16'h0000, 1'b0, 3'd7}, 1'b1, LONE_BAD_INDEX},
    '{'{KIND_REPORT, 8'h00, 16'hFFFF, 1'b0, 3'd0}, 1'b1, LONE_BUSY},
    '{'{KIND_ADD,    8'hFF, 16'h0000, 1'b0, 3'd0}, 1'b0, UNTYPED},
    '{'{KIND_ADD,    8'hFF, 16'hFFFF, 1'b1, 3'd7}, 1'b0, UNTYPED},
    '{'{KIND_REPORT, 8'hFF, 16'd100,  1'b0, 3'd0}, 1'b0, UNTYPED},
    '{'{KIND_SWITCH, 8'hFF, 16'h0000, 1'b0, 3'd0}, 1'b0, UNTYPED},
    '{'{KIND_SWITCH, 8'h00, 16'h0000, 1'b0, 3'd0}, 1'b0, UNTYPED},
    '{'{KIND_REPORT, 8'h00, 16'hFFFF, 1'b0, 3'd0}, 1'b0, UNTYPED},
    '{'{KIND_REPORT, 8'h00, 16'h0000, 1'b0, 3'd0}, 1'b0, UNTYPED},
    '{'{KIND_ADD,    8'h01, 16'h0000, 1'b0, 3'd0}, 1'b0, UNTYPED},
    '{'{KIND_ADD,    8'h80, 16'h0000, 1'b0, 3'd0}, 1'b0, UNTYPED},
    '{'{KIND_ADD,    8'h7F, 16'h0000, 1'b0, 3'd0}, 1'b0, UNTYPED},
    '{'{KIND_ADD,    8'h02, 16'h0000, 1'b0, 3'd0}, 1'b0, UNTYPED},
    '{'{KIND_ADD,    8'h03, 16'h0000, 1'b0, 3'd0}, 1'b0, UNTYPED},
    '{'{KIND_ADD,    8'h04, 16'h0000, 1'b0, 3'd0}, 1'b0, UNTYPED},
    '{'{KIND_REMOVE, 8'h00, 16'h0000, 1'b0, 3'd1}, 1'b0, UNTYPED},
    '{'{KIND_REMOVE, 8'h00, 16'h0000, 1'b0, 3'd7}, 1'b0, UNTYPED},
    '{'{KIND_SWITCH, 8'hFF, 16'h0000, 1'b1, 3'd0}, 1'b0, UNTYPED},
    '{'{KIND_REMOVE, 8'h00, 16'h0000, 1'b0, 3'd6}, 1'b0, UNTYPED},
    '{'{KIND_REPORT, 8'h01, 16'd1,    1'b0, 3'd0}, 1'b0, UNTYPED},
    '{'{KIND_REPORT, 8'h01, 16'd2,    1'b0, 3'd0}, 1'b0, UNTYPED},
    '{'{KIND_SWITCH, 8'h80, 16'h0000, 1'b0, 3'd0}, 1'b0, UNTYPED}
  };

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;

  gnts_in_if  item_if ();
  gnts_out_if res_if ();

  grid_node_table_shed_select_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .item_i      (item_if),
    .result_o    (res_if)
  );

  // Predictor copy of the configuration and the node table.
  logic [UID_W-1:0]    pr_local_uid;
  logic [POWER_W-1:0]  pr_threshold;
  logic [ACT_W-1:0]    pr_ceiling;
  int unsigned         tbl_count;
  logic [UID_W-1:0]    tbl_id     [DEPTH];
  logic [POWER_W-1:0]  tbl_power  [DEPTH];
  logic [ENERGY_W-1:0] tbl_energy [DEPTH];
  logic [ACT_W-1:0]    tbl_act    [DEPTH];
  logic                tbl_shed   [DEPTH];

  gnts_result_t summary_q [$];
  int unsigned  mismatches;
  int unsigned  cycles;
  bit           steady;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic void clear_node(int unsigned k, logic [UID_W-1:0] id);
    tbl_id[k]     = id;
    tbl_power[k]  = '0;
    tbl_energy[k] = '0;
    tbl_act[k]    = '0;
    tbl_shed[k]   = 1'b0;
  endfunction

  // Applies one word to the table copy and returns the summary it produces.
  function automatic gnts_result_t table_apply(gnts_item_t w);
    gnts_result_t       r;
    int unsigned        k;
    int unsigned        hit;
    bit                 found;
    logic [ENERGY_W:0]  esum;
    logic [ACT_W-1:0]   best_act;
    logic [ACT_W-1:0]   quiet_min;
    r = '0;
    r.status = STATUS_OK;
    found = 1'b0;
    hit = 0;
    case (w.kind)
      KIND_ADD: begin
        if (tbl_count >= DEPTH) begin
          r.status = STATUS_FULL;
        end else begin
          clear_node(tbl_count, w.uid);
          tbl_count++;
        end
      end
      KIND_REPORT: begin
        // The last entry with a matching UID takes the report.
        for (k = 0; k < tbl_count; k++)
          if (tbl_id[k] == w.uid) begin
            found = 1'b1;
            hit = k;
          end
        if (!found) begin
          r.status = STATUS_NOT_FOUND;
        end else begin
          esum = {1'b0, tbl_energy[hit]} + w.power;
          tbl_energy[hit] = esum[ENERGY_W] ? '1 : esum[ENERGY_W-1:0];
          if (w.power > tbl_power[hit] && tbl_act[hit] != '1)
            tbl_act[hit] = tbl_act[hit] + 1'b1;
          tbl_power[hit] = w.power;
        end
      end
      KIND_SWITCH: begin
        // The first matching entry is switched.
        for (k = 0; k < tbl_count && !found; k++)
          if (tbl_id[k] == w.uid) begin
            found = 1'b1;
            hit = k;
          end
        if (!found) r.status = STATUS_NOT_FOUND;
        else tbl_shed[hit] = ~w.switch_on;
      end
      default: begin
        if (w.entry_index == 0 || w.entry_index >= tbl_count) begin
          r.status = STATUS_BAD_INDEX;
        end else begin
          for (k = w.entry_index; k + 1 < tbl_count; k++) begin
            tbl_id[k]     = tbl_id[k+1];
            tbl_power[k]  = tbl_power[k+1];
            tbl_energy[k] = tbl_energy[k+1];
            tbl_act[k]    = tbl_act[k+1];
            tbl_shed[k]   = tbl_shed[k+1];
          end
          tbl_count--;
          clear_node(tbl_count, '0);
        end
      end
    endcase
    best_act = '0;
    quiet_min = pr_ceiling;
    for (k = 0; k < tbl_count; k++) begin
      if (tbl_power[k] > pr_threshold) begin
        r.consuming_count++;
        if (tbl_act[k] > best_act) begin
          best_act = tbl_act[k];
          r.busiest_uid = tbl_id[k];
          r.busiest_valid = 1'b1;
        end
      end
      if (tbl_shed[k]) begin
        r.shed_count++;
        if (tbl_act[k] < quiet_min) begin
          quiet_min = tbl_act[k];
          r.quietest_shed_uid = tbl_id[k];
          r.quietest_valid = 1'b1;
        end
      end
    end
    r.node_count = tbl_count[OCNT_W-1:0];
    return r;
  endfunction

  // Mostly UIDs that are in the table, so reports and switches reach real entries.
  function automatic gnts_item_t rand_word();
    gnts_item_t  w;
    int unsigned sel;
    int          p;
    sel = $urandom_range(0, 99);
    if (sel < 22) w.kind = KIND_ADD;
    else if (sel < 60) w.kind = KIND_REPORT;
    else if (sel < 82) w.kind = KIND_SWITCH;
    else w.kind = KIND_REMOVE;
    sel = $urandom_range(0, 99);
    if (sel < 65) w.uid = tbl_id[$urandom_range(0, tbl_count - 1)];
    else if (sel < 85) w.uid = UID_W'($urandom_range(1, 6));
    else w.uid = UID_W'($urandom_range(0, 255));
    sel = $urandom_range(0, 9);
    case (sel)
      0: w.power = '0;
      1: w.power = '1;
      2, 3: begin
        p = int'(pr_threshold) + int'($urandom_range(0, 4)) - 2;
        if (p < 0) p = 0;
        if (p > 65535) p = 65535;
        w.power = POWER_W'(p);
      end
      4, 5, 6: w.power = POWER_W'($urandom_range(0, 600));
      default: w.power = POWER_W'($urandom_range(0, 65535));
    endcase
    w.switch_on = 1'($urandom_range(0, 1));
    if (w.kind == KIND_REMOVE && tbl_count > 1 && $urandom_range(0, 99) < 80)
      w.entry_index = EIDX_W'($urandom_range(1, tbl_count - 1));
    else
      w.entry_index = EIDX_W'($urandom_range(0, 7));
    return w;
  endfunction

  // Called at a rising edge; returns at the edge that accepts the word.
  task automatic send_word(gnts_item_t w, logic typed, gnts_result_t r);
    gnts_result_t pred;
    if (!steady && $urandom_range(0, 99) < 25) begin
      item_if.valid <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk_i);
    end
    item_if.valid <= 1'b1;
    item_if.data  <= w;
    do @(posedge clk_i); while (!item_if.ready);
    pred = table_apply(w);
    summary_q.push_back(typed ? r : pred);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    case (idx)
      CFG_LOCAL_UID: begin
        pr_local_uid = val[UID_W-1:0];
        tbl_id[0] = val[UID_W-1:0];
      end
      CFG_CONSUME_THR: pr_threshold = val[POWER_W-1:0];
      default: pr_ceiling = val[ACT_W-1:0];
    endcase
  endtask

  // Result side: random stalls, and every accepted word is checked against the oldest entry.
  always @(posedge clk_i) begin
    gnts_result_t want;
    gnts_result_t got;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got = res_if.data;
      if (summary_q.size() == 0) begin
        $error("unexpected result word %h", got);
        mismatches++;
      end else begin
        want = summary_q.pop_front();
        if (got.status != want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          mismatches++;
        end
        if (got.node_count != want.node_count) begin
          $error("node_count: expected %0d, got %0d", want.node_count, got.node_count);
          mismatches++;
        end
        if (got.consuming_count != want.consuming_count) begin
          $error("consuming_count: expected %0d, got %0d",
                 want.consuming_count, got.consuming_count);
          mismatches++;
        end
        if (got.shed_count != want.shed_count) begin
          $error("shed_count: expected %0d, got %0d", want.shed_count, got.shed_count);
          mismatches++;
        end
        if (got.busiest_uid != want.busiest_uid) begin
          $error("busiest_uid: expected %0d, got %0d", want.busiest_uid, got.busiest_uid);
          mismatches++;
        end
        if (got.busiest_valid != want.busiest_valid) begin
          $error("busiest_valid: expected %0d, got %0d",
                 want.busiest_valid, got.busiest_valid);
          mismatches++;
        end
        if (got.quietest_shed_uid != want.quietest_shed_uid) begin
          $error("quietest_shed_uid: expected %0d, got %0d",
                 want.quietest_shed_uid, got.quietest_shed_uid);
          mismatches++;
        end
        if (got.quietest_valid != want.quietest_valid) begin
          $error("quietest_valid: expected %0d, got %0d",
                 want.quietest_valid, got.quietest_valid);
          mismatches++;
        end
      end
    end
    res_if.ready <= steady || ($urandom_range(0, 99) >= 18);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int unsigned n;
    int unsigned ph;
    rst_ni        = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = CFG_LOCAL_UID;
    cfg_wdata     = '0;
    item_if.valid = 1'b0;
    item_if.data  = '0;
    steady        = 1'b0;
    pr_local_uid  = LOCAL_UID_RST;
    pr_threshold  = CONSUME_THR_RST;
    pr_ceiling    = ACT_CEIL_RST;
    for (n = 0; n < DEPTH; n++) clear_node(n, '0);
    tbl_count = 1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      // The table is idle here: every result so far has been taken.
      case (ph)
        1: begin
          write_reg(CFG_LOCAL_UID, 16'h00FF);
          write_reg(CFG_CONSUME_THR, 16'h0000);
          write_reg(CFG_ACT_CEIL, 16'h0000);
          cfg_we <= 1'b0;
        end
        2: begin
          write_reg(CFG_LOCAL_UID, 16'h005A);
          write_reg(CFG_CONSUME_THR, 16'hFFFF);
          write_reg(CFG_ACT_CEIL, 16'hFFFF);
          cfg_we <= 1'b0;
        end
        3: begin
          write_reg(CFG_LOCAL_UID, CFG_W'($urandom_range(0, 255)));
          write_reg(CFG_CONSUME_THR, CFG_W'($urandom_range(0, 400)));
          write_reg(CFG_ACT_CEIL, CFG_W'($urandom_range(1, 4)));
          cfg_we <= 1'b0;
        end
        4: begin
          write_reg(CFG_LOCAL_UID, CFG_W'(LOCAL_UID_RST));
          write_reg(CFG_CONSUME_THR, CFG_W'(CONSUME_THR_RST));
          write_reg(CFG_ACT_CEIL, CFG_W'(ACT_CEIL_RST));
          cfg_we <= 1'b0;
        end
        default: begin
          foreach (DIR_ROWS[k]) send_word(DIR_ROWS[k].w, DIR_ROWS[k].typed, DIR_ROWS[k].r);
        end
      endcase
      for (n = 0; n < RANDOM_PER_PHASE; n++) begin
        steady = (ph == 2) && (n < STEADY_WORDS);
        send_word(rand_word(), 1'b0, UNTYPED);
      end
      steady = 1'b0;
      item_if.valid <= 1'b0;
      while (summary_q.size() != 0) @(posedge clk_i);
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && summary_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
